// File: rtl/blowfish_block_cipher_defines.svh
// Assertion helpers for the cipher core; both sample on clk and mute while rst_n is low.
`ifndef BLOWFISH_BLOCK_CIPHER_DEFINES_SVH
`define BLOWFISH_BLOCK_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cipher core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cipher core assertion failed");

`endif

// File: rtl/bf_pkg.sv
package bf_pkg;

    localparam int WORD_W     = 32;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 10;
    localparam int KEY_DEPTH  = 18;
    localparam int KEY_AW     = 5;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;
    localparam int NUM_SBOX   = 4;
    localparam int BANK_W     = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD_KEY  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_SBOX = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ENCRYPT   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DECRYPT   = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Read data of the four S-boxes, S-box 0 at index 0.
    typedef logic [NUM_SBOX-1:0][WORD_W-1:0] sbox_quad_t;

endpackage

// File: rtl/bf_ram.sv
module bf_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [bf_pkg::WORD_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [bf_pkg::WORD_W-1:0] rd_data
);
    import bf_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bf_feistel.sv
module bf_feistel (
    input  bf_pkg::sbox_quad_t sbox_q,
    output bf_pkg::word_t      f_out
);
    import bf_pkg::*;

    word_t sum_w;

    // F = ((S0 + S1) ^ S2) + S3, all sums modulo 2^32.
    assign sum_w = sbox_q[0] + sbox_q[1];
    assign f_out = (sum_w ^ sbox_q[2]) + sbox_q[3];

endmodule

// File: rtl/blowfish_block_cipher.sv
// Encrypt or decrypt request: once it is accepted, the sequencer steps through PRE, RUN
// and FIN, and FIN hands the result to the output register. RUN does the round loop
// through the S-box memories (registered read, one round per cycle); FIN waits until the
// output register is free. Only in IDLE is a request taken; a load leaves the sequencer idle.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the result valid flag;
// subkey and S-box memories keep no reset and hold undefined data until software loads them.
`include "blowfish_block_cipher_defines.svh"

module blowfish_block_cipher #(
    parameter int ROUNDS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bf_pkg::ACT_W-1:0]  action,
    input  logic [bf_pkg::IDX_W-1:0]  table_index,
    input  logic [bf_pkg::WORD_W-1:0] table_word,
    input  logic [bf_pkg::WORD_W-1:0] left_half,
    input  logic [bf_pkg::WORD_W-1:0] right_half,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bf_pkg::WORD_W-1:0] left_out,
    output logic [bf_pkg::WORD_W-1:0] right_out
);
    import bf_pkg::*;

    // The subkey issue counter runs from 0 to ROUNDS+1 and steps once past that.
    localparam int CNT_W = $clog2(ROUNDS + 3);
    localparam logic [CNT_W-1:0]  CNT_LAST_ROUND = CNT_W'(ROUNDS + 1);
    localparam logic [KEY_AW-1:0] KEY_LAST       = KEY_AW'(ROUNDS + 1);

    // Sequencer states. PRE applies the first subkey; RUN does one Feistel round per
    // cycle; FIN applies the last whitening subkey and hands the block to the output.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PRE  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dec_reg, dec_next;
    word_t            l_reg, l_next;
    word_t            r_reg, r_next;
    logic             out_valid_reg, out_valid_next;
    word_t            left_out_reg, left_out_next;
    word_t            right_out_reg, right_out_next;

    logic             accept_w;
    logic             is_xform_w;
    logic             out_free_w;
    logic             key_we_w;
    logic             sbox_we_w;
    logic             key_re_w;
    logic [CNT_W-1:0] key_cnt_w;
    logic             key_dec_w;
    logic [KEY_AW-1:0] key_raddr_w;
    word_t            key_q_w;
    sbox_quad_t       sbox_q_w;
    word_t            f_w;
    word_t            new_r_w;
    word_t            sbox_addr_word_w;

    // Requests are taken only while the sequencer is idle; the output register parts
    // the two channels so a waiting result never blocks the next request.
    assign in_stall   = (st_reg != ST_IDLE);
    assign accept_w   = in_valid && !in_stall;
    assign is_xform_w = (action == ACT_ENCRYPT) || (action == ACT_DECRYPT);
    assign out_free_w = !out_valid_reg || !out_stall;

    // Subkey writes beyond the end of the array are dropped.
    assign key_we_w  = accept_w && (action == ACT_LOAD_KEY) &&
                       (table_index < IDX_W'(KEY_DEPTH));
    assign sbox_we_w = accept_w && (action == ACT_LOAD_SBOX);

    // Subkey fetch order. Encryption reads index c at step c; decryption reads
    // ROUNDS+1-c. Steps 0..ROUNDS-1 feed the rounds, steps ROUNDS and ROUNDS+1 the
    // whitening of the right and then the left half. The fetch runs one step ahead.
    assign key_cnt_w   = (st_reg == ST_IDLE) ? '0 : cnt_reg;
    assign key_dec_w   = (st_reg == ST_IDLE) ? (action == ACT_DECRYPT) : dec_reg;
    assign key_raddr_w = key_dec_w ? (KEY_LAST - KEY_AW'(key_cnt_w)) : KEY_AW'(key_cnt_w);
    assign key_re_w    = (accept_w && is_xform_w) || (st_reg == ST_PRE) || (st_reg == ST_RUN);

    bf_ram #(
        .DEPTH  (KEY_DEPTH),
        .ADDR_W (KEY_AW)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we_w),
        .wr_addr (table_index[KEY_AW-1:0]),
        .wr_data (table_word),
        .rd_en   (key_re_w),
        .rd_addr (key_raddr_w),
        .rd_data (key_q_w)
    );

    // Round datapath. In RUN, l_reg holds the left half after its subkey XOR, which is the
    // word whose S-box lookups are in flight; r_reg holds the right half.
    bf_feistel u_feistel (
        .sbox_q (sbox_q_w),
        .f_out  (f_w)
    );

    assign new_r_w          = r_reg ^ f_w;
    assign sbox_addr_word_w = (st_reg == ST_PRE) ? (l_reg ^ key_q_w) : (new_r_w ^ key_q_w);

    // One memory per S-box, each read at one byte of the next left half.
    for (genvar g = 0; g < NUM_SBOX; g++)
    begin : g_sbox
        bf_ram #(
            .DEPTH  (SBOX_DEPTH),
            .ADDR_W (SBOX_AW)
        ) u_sbox_ram (
            .clk     (clk),
            .wr_en   (sbox_we_w && (table_index[IDX_W-1:SBOX_AW] == BANK_W'(g))),
            .wr_addr (table_index[SBOX_AW-1:0]),
            .wr_data (table_word),
            .rd_en   (1'b1),
            .rd_addr (sbox_addr_word_w[(NUM_SBOX-1-g)*SBOX_AW +: SBOX_AW]),
            .rd_data (sbox_q_w[g])
        );
    end

    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        dec_next       = dec_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept_w && is_xform_w)
                begin
                    l_next   = left_half;
                    r_next   = right_half;
                    dec_next = (action == ACT_DECRYPT);
                    cnt_next = CNT_W'(1);
                    st_next  = ST_PRE;
                end
            end
            ST_PRE:
            begin
                l_next   = l_reg ^ key_q_w;
                cnt_next = cnt_reg + CNT_W'(1);
                st_next  = ST_RUN;
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST_ROUND)
                begin
                    // Last round: the swap is undone, so the left half stays and the
                    // right half takes its whitening subkey.
                    r_next  = new_r_w ^ key_q_w;
                    st_next = ST_FIN;
                end
                else
                begin
                    l_next = new_r_w ^ key_q_w;
                    r_next = l_reg;
                end
            end
            ST_FIN:
            begin
                // The subkey read data holds here until the output register is free.
                if (out_free_w)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = l_reg ^ key_q_w;
                    right_out_next = r_reg;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        dec_reg       <= dec_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // A result only appears right after the sequencer finished a block.
    `BF_ASSERT_IMPL(a_result_after_fin, $rose(out_valid_reg), $past(st_reg) == ST_FIN)
    // An accepted transform starts the sequencer on the next cycle.
    `BF_ASSERT_NEXT(a_xform_starts, accept_w && is_xform_w, st_reg == ST_PRE)
    // Rounds run only with the subkey counter inside its round window.
    `BF_ASSERT_IMPL(a_run_count, st_reg == ST_RUN, (cnt_reg >= CNT_W'(2)) && (cnt_reg <= CNT_LAST_ROUND))
    // A finished block waiting on a full output keeps the sequencer parked in FIN.
    `BF_ASSERT_NEXT(a_fin_holds, (st_reg == ST_FIN) && !out_free_w, st_reg == ST_FIN)

endmodule

// File: dv/tb_blowfish_block_cipher.sv
module tb_blowfish_block_cipher;

    timeunit 1ns;
    timeprecision 1ps;

    import bf_pkg::*;

    // The core is built with its full round count. Both the DUT and the local
    // cipher calculation take it from here.
    localparam int ROUNDS = 16;

    // Longest run of cycles with no request and no result moving before the
    // run is declared hung. The longest correct quiet stretch is the forced
    // receiver hold below plus one transform, so this is several times that.
    localparam int QUIET_LIMIT = 2000;

    // Length of the forced receiver hold, in cycles.
    localparam int HOLD_CYCLES = 300;

    // Number of S-box words over all four S-boxes.
    localparam int SBOX_WORDS = NUM_SBOX * SBOX_DEPTH;

    // One request as the driver presents it.
    typedef struct {
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] index;
        word_t            word;
        word_t            left_in;
        word_t            right_in;
    } bf_request_t;

    // One transformed block as the core returns it.
    typedef struct {
        word_t left;
        word_t right;
    } bf_block_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [ACT_W-1:0] action = ACT_LOAD_KEY;
    logic [IDX_W-1:0] table_index = '0;
    word_t            table_word = '0;
    word_t            left_half = '0;
    word_t            right_half = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    word_t            left_out;
    word_t            right_out;

    // Requests waiting for the driver, and blocks the core still owes us.
    bf_request_t pending_requests[$];
    bf_block_t   expected_blocks[$];

    // Our own copy of the key tables, updated in the order that the core
    // accepts the load requests.
    word_t subkey_mem [0:KEY_DEPTH-1];
    word_t sbox_mem   [0:SBOX_WORDS-1];

    // Idle rates for each side, in percent, set per phase by the stimulus.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // The stimulus asks for a long receiver hold by raising hold_requests.
    // The monitor serves each one and counts the hold in its own process.
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int          hold_left = 0;

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    blowfish_block_cipher #(
        .ROUNDS      (ROUNDS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .table_index (table_index),
        .table_word  (table_word),
        .left_half   (left_half),
        .right_half  (right_half),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_out    (left_out),
        .right_out   (right_out)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Blowfish round function over our S-box copy. S-box n lives at
    // n*256 + entry, and all sums wrap at 32 bits.
    function automatic word_t round_mix(word_t x);
        word_t s0;
        word_t s1;
        word_t s2;
        word_t s3;
        s0 = sbox_mem[{2'd0, x[31:24]}];
        s1 = sbox_mem[{2'd1, x[23:16]}];
        s2 = sbox_mem[{2'd2, x[15:8]}];
        s3 = sbox_mem[{2'd3, x[7:0]}];
        return ((s0 + s1) ^ s2) + s3;
    endfunction

    // Full Feistel pass. Encryption walks the subkeys upward and whitens with
    // the two after the last round; decryption walks them downward from the
    // top and whitens with the first two.
    function automatic bf_block_t cipher_block(bit decrypt, word_t l_in, word_t r_in);
        word_t     l;
        word_t     r;
        word_t     t;
        int        i;
        int        k;
        bf_block_t res;
        l = l_in;
        r = r_in;
        for (i = 0; i < ROUNDS; i++)
        begin
            k = decrypt ? ROUNDS + 1 - i : i;
            l = l ^ subkey_mem[k % KEY_DEPTH];
            r = r ^ round_mix(l);
            t = l;
            l = r;
            r = t;
        end
        // Undo the swap of the last round.
        t = l;
        l = r;
        r = t;
        if (decrypt)
        begin
            r = r ^ subkey_mem[1];
            l = l ^ subkey_mem[0];
        end
        else
        begin
            r = r ^ subkey_mem[ROUNDS % KEY_DEPTH];
            l = l ^ subkey_mem[(ROUNDS + 1) % KEY_DEPTH];
        end
        res.left = l;
        res.right = r;
        return res;
    endfunction

    // Data words lean toward the extremes now and then.
    function automatic word_t pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] index,
                                 word_t word, word_t l_in, word_t r_in);
        bf_request_t req;
        req.act = act;
        req.index = index;
        req.word = word;
        req.left_in = l_in;
        req.right_in = r_in;
        pending_requests.push_back(req);
    endtask

    // Mostly encrypt and decrypt requests, with table reloads mixed in so
    // that later transforms run on changed keys. Subkey loads past the end
    // of the array are ignored by the core and are not counted.
    task automatic queue_random_requests(int count);
        int left_to_queue;
        int pick;
        left_to_queue = count;
        while (left_to_queue > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                queue_request(ACT_ENCRYPT, IDX_W'($urandom), $urandom,
                              pick_word(), pick_word());
            end
            else if (pick < 80)
            begin
                queue_request(ACT_DECRYPT, IDX_W'($urandom), $urandom,
                              pick_word(), pick_word());
            end
            else if (pick < 88)
            begin
                queue_request(ACT_LOAD_SBOX, IDX_W'($urandom_range(SBOX_WORDS - 1)),
                              pick_word(), $urandom, $urandom);
            end
            else if (pick < 96)
            begin
                queue_request(ACT_LOAD_KEY, IDX_W'($urandom_range(KEY_DEPTH - 1)),
                              pick_word(), $urandom, $urandom);
            end
            else
            begin
                queue_request(ACT_LOAD_KEY,
                              IDX_W'($urandom_range(SBOX_WORDS - 1, KEY_DEPTH)),
                              pick_word(), $urandom, $urandom);
                left_to_queue++;
            end
            left_to_queue--;
        end
    endtask

    // The sender stops until every queued request has gone in and every
    // block it caused has come back.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_blocks.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what, bf_block_t want, word_t got_l, word_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s: expected left %h right %h, got left %h right %h",
                     $realtime, what, want.left, want.right, got_l, got_r);
    endtask

    // Driver. The next request is loaded only when the bus is free, that is
    // when nothing is offered or the offered request is taken at this edge.
    // A stalled request stays on the bus untouched.
    always @(posedge clk or negedge rst_n)
    begin : driver
        bf_request_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_LOAD_KEY;
            table_index <= '0;
            table_word <= '0;
            left_half <= '0;
            right_half <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_requests.pop_front();
                in_valid <= 1'b1;
                action <= next_req.act;
                table_index <= next_req.index;
                table_word <= next_req.word;
                left_half <= next_req.left_in;
                right_half <= next_req.right_in;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Results are checked before the request taken at the same edge
    // is folded into the prediction, so the order is fixed by the code here.
    // It also drives the receiver stall and keeps the quiet-cycle count.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bf_block_t want;
        bf_block_t none;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            quiet_cycles <= 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    none.left = '0;
                    none.right = '0;
                    report_mismatch("result with no request outstanding", none,
                                    left_out, right_out);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (want.left !== left_out || want.right !== right_out)
                        report_mismatch("block mismatch", want, left_out, right_out);
                end
            end

            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_LOAD_KEY:
                    begin
                        // Indexes past the subkey array are dropped by the core.
                        if (table_index < KEY_DEPTH)
                            subkey_mem[table_index[KEY_AW-1:0]] = table_word;
                    end
                    ACT_LOAD_SBOX:
                        sbox_mem[table_index] = table_word;
                    ACT_ENCRYPT:
                        expected_blocks.push_back(cipher_block(1'b0, left_half, right_half));
                    ACT_DECRYPT:
                        expected_blocks.push_back(cipher_block(1'b1, left_half, right_half));
                endcase
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            // A requested hold keeps the output stalled for a fixed stretch so
            // that the core backs up and has to stall its input.
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // A run that stops moving ends here.
    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: the sender idles often, the receiver even more.
        send_idle_pct = 36;
        recv_idle_pct = 62;

        // Every table entry is written before the first transform, since any
        // entry can be read by some block. The first and last words of each
        // table get the all-zero and all-one extremes.
        for (n = 0; n < KEY_DEPTH; n++)
        begin
            queue_request(ACT_LOAD_KEY, IDX_W'(n),
                          (n == 0) ? '0 : ((n == KEY_DEPTH - 1) ? '1 : $urandom),
                          $urandom, $urandom);
        end
        for (n = 0; n < SBOX_WORDS; n++)
        begin
            queue_request(ACT_LOAD_SBOX, IDX_W'(n),
                          (n == 0) ? '0 : ((n == SBOX_WORDS - 1) ? '1 : $urandom),
                          $urandom, $urandom);
        end

        // Subkey loads just past the array and at the top index must leave
        // the keys alone; the transforms that follow show whether they did.
        queue_request(ACT_LOAD_KEY, IDX_W'(KEY_DEPTH), '1, $urandom, $urandom);
        queue_request(ACT_LOAD_KEY, '1, '1, $urandom, $urandom);

        // Extreme blocks in both directions.
        queue_request(ACT_ENCRYPT, '0, '0, '0, '0);
        queue_request(ACT_ENCRYPT, '1, '1, '1, '1);
        queue_request(ACT_ENCRYPT, '0, '1, '0, '1);
        queue_request(ACT_ENCRYPT, '1, '0, '1, '0);
        queue_request(ACT_DECRYPT, '0, '0, '0, '0);
        queue_request(ACT_DECRYPT, '1, '1, '1, '1);
        queue_request(ACT_DECRYPT, '0, '1, '0, '1);
        queue_request(ACT_DECRYPT, '1, '0, '1, '0);

        // Reloads right before a transform that depends on them.
        queue_request(ACT_LOAD_KEY, IDX_W'(5), '1, '0, '0);
        queue_request(ACT_ENCRYPT, '0, '0, $urandom, $urandom);
        queue_request(ACT_LOAD_SBOX, '1, '0, '1, '1);
        queue_request(ACT_DECRYPT, '0, '0, '1, '1);
        queue_request(ACT_LOAD_SBOX, '0, '1, '0, '0);
        queue_request(ACT_ENCRYPT, '1, '1, '0, '0);

        queue_random_requests(120);
        // The sender pauses here until the core has emptied out.
        wait_drained();
        queue_random_requests(120);
        wait_drained();

        // Phase two: the rates swap sides.
        send_idle_pct = 62;
        recv_idle_pct = 36;
        queue_random_requests(240);
        wait_drained();

        // Phase three: nobody idles. A long receiver hold starts while the
        // sender keeps offering requests, so the core fills up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(130);
        hold_requests++;
        queue_random_requests(130);
        wait_drained();

        // Let a late or stray result show up before the verdict.
        repeat (ROUNDS + 8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && expected_blocks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: blowfish_block_cipher.f
+incdir+rtl
rtl/bf_pkg.sv
rtl/bf_ram.sv
rtl/bf_feistel.sv
rtl/blowfish_block_cipher.sv
dv/tb_blowfish_block_cipher.sv
